// File: sv/aa2rm_pkg.sv
// ============================================================================
// Axis-angle to rotation matrix: shared types, constants and stage functions
// Holds the fixed-point constants, the arctangent table and the per-stage
// arithmetic of the front pipeline (norm, angle reduction, CORDIC, division).
// ============================================================================
package aa2rm_pkg;

    // Front pipeline stage positions.
    localparam int unsigned SQ_FIRST   = 3;
    localparam int unsigned SQ_STEPS   = 20;
    localparam int unsigned PROD_IDX   = 23;
    localparam int unsigned MOD_FIRST  = 24;
    localparam int unsigned MOD_STEPS  = 10;
    localparam int unsigned FOLD_IDX   = 34;
    localparam int unsigned COR_FIRST  = 35;
    localparam int unsigned DIV_FIRST  = 24;
    localparam int unsigned DIV_STEPS  = 31;
    localparam int unsigned TAIL_DEPTH = 4;

    localparam logic        [41:0] TWO_PI_Q30   = 42'd6746518852;
    localparam logic signed [33:0] TWO_PI_S     = 34'sd6746518852;
    localparam logic signed [33:0] PI_Q30       = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_Q30  = 34'sd1686629713;
    localparam logic signed [33:0] CORDIC_GAIN  = 34'sh026DD3B6A;
    localparam logic signed [15:0] Q14_ONE      = 16'sd16384;

    localparam logic [31:0] ATAN_Q30 [32] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
        32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
        32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
        32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
        32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000007,
        32'h00000003, 32'h00000001, 32'h00000000, 32'h00000000
    };

    typedef struct packed {
        logic                   zero;
        logic [2:0]             wneg;
        logic [2:0][15:0]       wabs;
        logic [2:0][30:0]       sq;
        logic [39:0]            rad;
        logic [23:0]            rem;
        logic [19:0]            root;
        logic [41:0]            th;
        logic                   neg;
        logic signed [33:0]     x;
        logic signed [33:0]     y;
        logic signed [33:0]     z;
        logic [2:0][49:0]       drem;
        logic [2:0][30:0]       q;
    } t_front;

    // Q30 to Q2.14 with round half up and saturation.
    function automatic logic signed [15:0] to_q14(input logic signed [37:0] v);
        logic signed [37:0] t;
        t = (v + 38'sd32768) >>> 16;
        if (t > 38'sd32767) begin
            return 16'sh7FFF;
        end else if (t < -38'sd32768) begin
            return 16'sh8000;
        end
        return t[15:0];
    endfunction

    // One stage of the front pipeline; idx selects the work done in it.
    function automatic t_front front_step(input t_front s, input int unsigned idx,
                                         input logic [15:0] ts,
                                         input int unsigned cor_steps);
        t_front             n;
        logic [1:0]         two;
        logic [23:0]        trial;
        logic [23:0]        tsub;
        logic [35:0]        prod;
        logic [41:0]        cmod;
        logic signed [33:0] a;
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        logic signed [33:0] at;
        logic [49:0]        dsub;
        int unsigned        j;
        n = s;
        if (idx == 1) begin
            for (int c = 0; c < 3; c++) begin
                n.sq[c] = 31'(s.wabs[c]) * 31'(s.wabs[c]);
            end
        end
        if (idx == 2) begin
            n.rad  = {32'(s.sq[0]) + 32'(s.sq[1]) + 32'(s.sq[2]), 8'd0};
            n.rem  = '0;
            n.root = '0;
        end
        if (idx >= SQ_FIRST && idx < SQ_FIRST + SQ_STEPS) begin
            two   = s.rad[39:38];
            trial = {s.rem[21:0], two};
            tsub  = {2'b00, s.root, 2'b01};
            n.rad = {s.rad[37:0], 2'b00};
            if (trial >= tsub) begin
                n.rem  = trial - tsub;
                n.root = {s.root[18:0], 1'b1};
            end else begin
                n.rem  = trial;
                n.root = {s.root[18:0], 1'b0};
            end
        end
        if (idx == PROD_IDX) begin
            prod = 36'(s.root) * 36'(ts);
            n.th = {prod, 6'd0};
            for (int c = 0; c < 3; c++) begin
                n.drem[c] = {s.wabs[c], 34'd0};
                n.q[c]    = '0;
            end
        end
        if (idx >= MOD_FIRST && idx < MOD_FIRST + MOD_STEPS) begin
            j    = MOD_FIRST + MOD_STEPS - 1 - idx;
            cmod = TWO_PI_Q30 << j;
            if (s.th >= cmod) begin
                n.th = s.th - cmod;
            end
        end
        if (idx == FOLD_IDX) begin
            a     = $signed({1'b0, s.th[32:0]});
            n.neg = 1'b0;
            if (a > PI_Q30) begin
                a = a - TWO_PI_S;
            end
            if (a > HALF_PI_Q30) begin
                a     = a - PI_Q30;
                n.neg = 1'b1;
            end else if (a < -HALF_PI_Q30) begin
                a     = a + PI_Q30;
                n.neg = 1'b1;
            end
            n.x = CORDIC_GAIN;
            n.y = '0;
            n.z = a;
        end
        if (idx >= COR_FIRST && idx < COR_FIRST + cor_steps) begin
            j  = idx - COR_FIRST;
            dx = s.y >>> j;
            dy = s.x >>> j;
            at = $signed({2'b00, ATAN_Q30[5'(j)]});
            if (s.z >= 0) begin
                n.x = s.x - dx;
                n.y = s.y + dy;
                n.z = s.z - at;
            end else begin
                n.x = s.x + dx;
                n.y = s.y - dy;
                n.z = s.z + at;
            end
        end
        if (idx >= DIV_FIRST && idx < DIV_FIRST + DIV_STEPS) begin
            j    = DIV_FIRST + DIV_STEPS - 1 - idx;
            dsub = 50'(s.root) << j;
            for (int c = 0; c < 3; c++) begin
                if (s.drem[c] >= dsub) begin
                    n.drem[c]  = s.drem[c] - dsub;
                    n.q[c][j]  = 1'b1;
                end
            end
        end
        return n;
    endfunction

endpackage

// File: sv/axis_angle_to_rotation_matrix_top.sv
// ============================================================================
// Axis-angle to rotation matrix (Rodrigues formula)
// Turns an angular velocity vector and a configured time into the 3x3
// rotation matrix in signed Q2.14, one transaction per clock cycle unless stalled.
// ============================================================================
// The block accepts one vector (signed Q4.12) per clock cycle while the output
// is not stalled and returns one matrix per vector, in order. While
// CORDIC_STAGES is 20 or fewer the depth is set by the bit-serial square
// root (20 stages) followed by the three one-bit-per-stage dividers (31
// stages) that form the unit axis, with the CORDIC rotation (one stage per
// iteration) and the modulo-2*pi reduction (10 stages) running alongside;
// with more CORDIC stages (values beyond 32 count as 32) the rotation sets
// it. Each stage holds a valid bit and advances on its own whenever the
// stage after it is empty or moving, so bubbles collapse and the input keeps
// being taken while a finished matrix waits at the output, until every
// stage is full.
// The time scale register (unsigned Q8.8, reset 20.0) is written through its
// own channel, which is always ready; it must only be changed while no
// transaction is in flight. A zero vector gives the identity with zero_axis
// set.
module axis_angle_to_rotation_matrix_top #(
    parameter int unsigned CORDIC_STAGES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic        [15:0] i_cfg_time_scale,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_omega_x,
    input  logic signed [15:0] i_omega_y,
    input  logic signed [15:0] i_omega_z,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_r00,
    output logic signed [15:0] o_r01,
    output logic signed [15:0] o_r02,
    output logic signed [15:0] o_r10,
    output logic signed [15:0] o_r11,
    output logic signed [15:0] o_r12,
    output logic signed [15:0] o_r20,
    output logic signed [15:0] o_r21,
    output logic signed [15:0] o_r22,
    output logic               o_zero_axis
);
    import aa2rm_pkg::*;

    // Stages beyond 32 would only add zero angle steps, so they are dropped.
    localparam int unsigned COR_N  = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam int unsigned COR_END = COR_FIRST + COR_N;
    localparam int unsigned DIV_END = DIV_FIRST + DIV_STEPS;
    localparam int unsigned FRONT  = (COR_END > DIV_END) ? COR_END : DIV_END;
    localparam int unsigned TOTAL  = FRONT + TAIL_DEPTH;
    localparam int unsigned T0     = FRONT;
    localparam int unsigned T1     = FRONT + 1;
    localparam int unsigned T2     = FRONT + 2;
    localparam int unsigned T3     = FRONT + 3;

    logic [15:0]        r_time_scale;
    logic [TOTAL-1:0]   r_v;
    logic [TOTAL:0]     w_en;
    t_front             r_pipe [FRONT];
    t_front             n_pipe [FRONT];

    logic signed [33:0] r_t0_sn;
    logic signed [34:0] r_t0_om;
    logic signed [31:0] r_t0_k [3];
    logic               r_t0_zero;
    logic signed [31:0] r_t1_p [6];
    logic signed [33:0] r_t1_sk [3];
    logic signed [34:0] r_t1_om;
    logic               r_t1_zero;
    logic signed [35:0] r_t2_dg [3];
    logic signed [35:0] r_t2_od [3];
    logic signed [33:0] r_t2_sk [3];
    logic               r_t2_zero;
    logic signed [15:0] r_out [9];
    logic               r_zero;

    logic signed [33:0] n_t0_cs;
    logic signed [33:0] n_t0_sn;
    logic signed [31:0] n_t0_k [3];
    logic signed [63:0] w_pp [6];
    logic signed [65:0] w_sp [3];
    logic signed [32:0] w_pm [3];
    logic signed [67:0] w_dp [3];
    logic signed [67:0] w_op [3];
    logic signed [37:0] w_r [9];
    logic signed [15:0] n_out [9];

    // Configuration: a single register, always ready.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_scale <= 16'd5120;
        end else if (i_cfg_valid) begin
            r_time_scale <= i_cfg_time_scale;
        end
    end

    // A stage may load when it is empty or when the stage after it loads.
    assign w_en[TOTAL] = i_out_ready;
    for (genvar k = 0; k < TOTAL; k++) begin : g_en
        assign w_en[k] = !r_v[k] || w_en[k+1];
    end
    assign o_in_ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int k = 1; k < TOTAL; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Entry stage: split each component into magnitude and sign, flag a zero vector.
    always_comb begin
        n_pipe[0]         = '0;
        n_pipe[0].wneg    = {i_omega_z[15], i_omega_y[15], i_omega_x[15]};
        n_pipe[0].wabs[0] = i_omega_x[15] ? 16'(-i_omega_x) : i_omega_x;
        n_pipe[0].wabs[1] = i_omega_y[15] ? 16'(-i_omega_y) : i_omega_y;
        n_pipe[0].wabs[2] = i_omega_z[15] ? 16'(-i_omega_z) : i_omega_z;
        n_pipe[0].zero    = (i_omega_x == 16'sd0) && (i_omega_y == 16'sd0)
                            && (i_omega_z == 16'sd0);
    end

    for (genvar i = 1; i < FRONT; i++) begin : g_front
        assign n_pipe[i] = front_step(r_pipe[i-1], i, r_time_scale, COR_N);
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < FRONT; i++) begin
            if (w_en[i]) begin
                r_pipe[i] <= n_pipe[i];
            end
        end
    end

    // Tail stage 0: undo the angle fold, form 1 - cos and signed unit axis.
    always_comb begin
        n_t0_cs = r_pipe[FRONT-1].neg ? -r_pipe[FRONT-1].x : r_pipe[FRONT-1].x;
        n_t0_sn = r_pipe[FRONT-1].neg ? -r_pipe[FRONT-1].y : r_pipe[FRONT-1].y;
        for (int c = 0; c < 3; c++) begin
            n_t0_k[c] = r_pipe[FRONT-1].wneg[c] ? -$signed({1'b0, r_pipe[FRONT-1].q[c]})
                                                 :  $signed({1'b0, r_pipe[FRONT-1].q[c]});
        end
    end

    // Tail stage 1: axis outer products and sine terms.
    always_comb begin
        w_pp[0] = r_t0_k[0] * r_t0_k[0];
        w_pp[1] = r_t0_k[1] * r_t0_k[1];
        w_pp[2] = r_t0_k[2] * r_t0_k[2];
        w_pp[3] = r_t0_k[0] * r_t0_k[1];
        w_pp[4] = r_t0_k[0] * r_t0_k[2];
        w_pp[5] = r_t0_k[1] * r_t0_k[2];
        for (int c = 0; c < 3; c++) begin
            w_sp[c] = r_t0_sn * r_t0_k[c];
        end
    end

    // Tail stage 2: scale the squared skew terms by 1 - cos.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_pm[c] = 33'(r_t1_p[c]) - 33'sd1073741824;
            w_dp[c] = r_t1_om * w_pm[c];
            w_op[c] = r_t1_om * r_t1_p[c+3];
        end
    end

    // Tail stage 3: assemble the entries, round and saturate.
    always_comb begin
        w_r[0] = 38'sd1073741824 + 38'(r_t2_dg[0]);
        w_r[1] = 38'(r_t2_od[0]) - 38'(r_t2_sk[2]);
        w_r[2] = 38'(r_t2_od[1]) + 38'(r_t2_sk[1]);
        w_r[3] = 38'(r_t2_od[0]) + 38'(r_t2_sk[2]);
        w_r[4] = 38'sd1073741824 + 38'(r_t2_dg[1]);
        w_r[5] = 38'(r_t2_od[2]) - 38'(r_t2_sk[0]);
        w_r[6] = 38'(r_t2_od[1]) - 38'(r_t2_sk[1]);
        w_r[7] = 38'(r_t2_od[2]) + 38'(r_t2_sk[0]);
        w_r[8] = 38'sd1073741824 + 38'(r_t2_dg[2]);
        for (int e = 0; e < 9; e++) begin
            if (r_t2_zero) begin
                n_out[e] = ((e % 4) == 0) ? Q14_ONE : 16'sd0;
            end else begin
                n_out[e] = to_q14(w_r[e]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[T0]) begin
            r_t0_sn   <= n_t0_sn;
            r_t0_om   <= 35'sd1073741824 - 35'(n_t0_cs);
            r_t0_k    <= n_t0_k;
            r_t0_zero <= r_pipe[FRONT-1].zero;
        end
        if (w_en[T1]) begin
            for (int c = 0; c < 6; c++) begin
                r_t1_p[c] <= w_pp[c][61:30];
            end
            for (int c = 0; c < 3; c++) begin
                r_t1_sk[c] <= w_sp[c][63:30];
            end
            r_t1_om   <= r_t0_om;
            r_t1_zero <= r_t0_zero;
        end
        if (w_en[T2]) begin
            for (int c = 0; c < 3; c++) begin
                r_t2_dg[c] <= w_dp[c][65:30];
                r_t2_od[c] <= w_op[c][65:30];
            end
            r_t2_sk   <= r_t1_sk;
            r_t2_zero <= r_t1_zero;
        end
        if (w_en[T3]) begin
            r_out  <= n_out;
            r_zero <= r_t2_zero;
        end
    end

    assign o_out_valid = r_v[T3];
    assign o_r00       = r_out[0];
    assign o_r01       = r_out[1];
    assign o_r02       = r_out[2];
    assign o_r10       = r_out[3];
    assign o_r11       = r_out[4];
    assign o_r12       = r_out[5];
    assign o_r20       = r_out[6];
    assign o_r21       = r_out[7];
    assign o_r22       = r_out[8];
    assign o_zero_axis = r_zero;

    // An empty output stage must open the whole pipeline to new input.
    a_ready_when_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled while the output stage is empty");

    // A zero vector must come out as the identity.
    a_zero_identity : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_zero_axis) |-> (o_r00 == Q14_ONE && o_r11 == Q14_ONE
        && o_r22 == Q14_ONE && o_r01 == 16'sd0 && o_r02 == 16'sd0 && o_r10 == 16'sd0
        && o_r12 == 16'sd0 && o_r20 == 16'sd0 && o_r21 == 16'sd0))
        else $error("zero axis transaction is not the identity");

    // A stalled stage keeps its transaction until the next stage takes it.
    a_no_loss : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[T2] && !w_en[T3]) |=> r_v[T2])
        else $error("transaction lost in the matrix stages");

endmodule

// File: tb/sv/axis_angle_to_rotation_matrix_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// Rotation matrix checker
// Watches the vector, matrix and time scale channels, predicts each matrix
// with the Rodrigues formula in fixed point and compares it entry by entry.
// ============================================================================
module axis_angle_to_rotation_matrix_checker #(
    parameter int unsigned CORDIC_STAGES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic        [15:0] i_cfg_time_scale,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic signed [15:0] i_omega_x,
    input  logic signed [15:0] i_omega_y,
    input  logic signed [15:0] i_omega_z,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [15:0] i_r [9],
    input  logic               i_zero_axis,
    output int                 o_fail_count,
    output int                 o_pending
);
    import aa2rm_pkg::*;

    typedef struct {
        logic signed [15:0] r [9];
        logic               zero;
    } t_matrix;

    localparam longint ONE = 64'sd1073741824;

    t_matrix     matrix_q [$];
    logic [15:0] scale_shadow;

    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic signed [15:0] round_q14(longint v);
        longint t;
        t = (v + 32768) >>> 16;
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        return 16'(t);
    endfunction

    function automatic t_matrix rodrigues(longint w [3], logic [15:0] ts);
        t_matrix     m;
        longint      s, n, rb, v, a, x, y, z, dx, dy, sn, cs, om;
        longint      k [3];
        longint      p [3][3];
        longint      r [9];
        bit          neg;
        longint unsigned th;
        m.zero = 1'b0;
        if (w[0] == 0 && w[1] == 0 && w[2] == 0) begin
            foreach (m.r[i]) m.r[i] = (i % 4 == 0) ? 16'sd16384 : 16'sd0;
            m.zero = 1'b1;
            return m;
        end
        s = w[0] * w[0] + w[1] * w[1] + w[2] * w[2];
        // Integer square root of s * 2^8.
        v = s << 8;
        n = 0;
        rb = 64'sd1 << 60;
        while (rb > v) rb = rb >> 2;
        while (rb != 0) begin
            if (v >= n + rb) begin
                v = v - (n + rb);
                n = (n >> 1) + rb;
            end else begin
                n = n >> 1;
            end
            rb = rb >> 2;
        end
        th = ((unsigned'(n) * ts) << 6) % 64'd6746518852;
        a = longint'(th);
        neg = 0;
        if (a > 64'sd3373259426) a = a - 64'sd6746518852;
        if (a > 64'sd1686629713) begin
            a = a - 64'sd3373259426;
            neg = 1;
        end else if (a < -64'sd1686629713) begin
            a = a + 64'sd3373259426;
            neg = 1;
        end
        x = 64'sh26DD3B6A;
        y = 0;
        z = a;
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - longint'(ATAN_Q30[i]);
            end else begin
                x = x + dx; y = y - dy; z = z + longint'(ATAN_Q30[i]);
            end
        end
        cs = neg ? -x : x;
        sn = neg ? -y : y;
        om = ONE - cs;
        for (int i = 0; i < 3; i++) begin
            k[i] = ((w[i] < 0 ? -w[i] : w[i]) << 34) / n;
            if (w[i] < 0) k[i] = -k[i];
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                p[i][j] = fshr(k[i] * k[j], 30);
        for (int i = 0; i < 3; i++)
            r[i * 4] = ONE + fshr(om * (p[i][i] - ONE), 30);
        r[1] = -fshr(sn * k[2], 30) + fshr(om * p[0][1], 30);
        r[2] =  fshr(sn * k[1], 30) + fshr(om * p[0][2], 30);
        r[3] =  fshr(sn * k[2], 30) + fshr(om * p[0][1], 30);
        r[5] = -fshr(sn * k[0], 30) + fshr(om * p[1][2], 30);
        r[6] = -fshr(sn * k[1], 30) + fshr(om * p[0][2], 30);
        r[7] =  fshr(sn * k[0], 30) + fshr(om * p[1][2], 30);
        foreach (m.r[i]) m.r[i] = round_q14(r[i]);
        return m;
    endfunction

    always_ff @(posedge i_clk) begin
        t_matrix exp_m;
        longint  w [3];
        bit      bad;
        if (!i_rst_n) begin
            scale_shadow <= 16'd5120;
            o_fail_count <= 0;
            matrix_q.delete();
            o_pending    <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                scale_shadow <= i_cfg_time_scale;
            end
            if (i_in_valid && i_in_ready) begin
                w[0] = i_omega_x;
                w[1] = i_omega_y;
                w[2] = i_omega_z;
                matrix_q.push_back(rodrigues(w, scale_shadow));
            end
            if (i_out_valid && i_out_ready) begin
                if (matrix_q.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_fail_count < 10)
                        $display("Unexpected matrix transaction at %0t", $time);
                end else begin
                    exp_m = matrix_q.pop_front();
                    bad = (exp_m.zero != i_zero_axis);
                    foreach (exp_m.r[i]) if (exp_m.r[i] != i_r[i]) bad = 1;
                    if (bad) begin
                        o_fail_count <= o_fail_count + 1;
                        if (o_fail_count < 10) begin
                            $display("Matrix error at %0t, zero flag exp %0b got %0b",
                                     $time, exp_m.zero, i_zero_axis);
                            foreach (exp_m.r[i])
                                $display("  entry %0d: exp %0d got %0d", i,
                                         exp_m.r[i], i_r[i]);
                        end
                    end
                end
            end
            o_pending <= matrix_q.size();
        end
    end
endmodule

// File: tb/sv/axis_angle_to_rotation_matrix_top_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// Rotation matrix block testbench
// Drives vectors and time scale settings with random idling on both sides;
// the checker predicts and compares every matrix.
// ============================================================================
module axis_angle_to_rotation_matrix_top_tb;

    // The settle time stays well above the pipeline latency at 20 CORDIC stages
    // or fewer.
    localparam int SETTLE = 120;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic        [15:0] cfg_scale = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [15:0] wx = '0, wy = '0, wz = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [15:0] r [9];
    logic               zero_axis;
    int                 fail_count;
    int                 pending;
    bit                 quiet = 0;

    // The clock has a period of 4 ns.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    axis_angle_to_rotation_matrix_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_time_scale (cfg_scale),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_omega_x        (wx),
        .i_omega_y        (wy),
        .i_omega_z        (wz),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_r00 (r[0]), .o_r01 (r[1]), .o_r02 (r[2]),
        .o_r10 (r[3]), .o_r11 (r[4]), .o_r12 (r[5]),
        .o_r20 (r[6]), .o_r21 (r[7]), .o_r22 (r[8]),
        .o_zero_axis      (zero_axis)
    );

    axis_angle_to_rotation_matrix_checker u_checker (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_cfg_valid (cfg_valid), .i_cfg_ready (cfg_ready),
        .i_cfg_time_scale (cfg_scale),
        .i_in_valid (in_valid), .i_in_ready (in_ready),
        .i_omega_x (wx), .i_omega_y (wy), .i_omega_z (wz),
        .i_out_valid (out_valid), .i_out_ready (out_ready),
        .i_r (r), .i_zero_axis (zero_axis),
        .o_fail_count (fail_count), .o_pending (pending)
    );

    // The receiver stalls in random bursts until the final part of the run,
    // when it is always ready.
    always @(posedge i_clk) begin
        int stall;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 6);
            out_ready <= 1'b0;
            repeat (stall) @(posedge i_clk);
        end
        out_ready <= 1'b1;
    end

    // Sends one vector transaction, holding it until the block accepts it.
    task automatic send_vector(logic signed [15:0] x, logic signed [15:0] y,
                               logic signed [15:0] z);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        wx <= x;
        wy <= y;
        wz <= z;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    // Drains all outstanding matrices, waits out the pipeline, then sets the
    // time scale while nothing is in flight.
    task automatic set_scale(logic [15:0] ts);
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_scale <= ts;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly small or moderate vectors, with occasional full-range values,
    // single-axis vectors and zero vectors.
    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return 16'sd0;
            2: return 16'($signed($urandom_range(0, 255)) - 128);
            default: return 16'($signed($urandom_range(0, 16383)) - 8192);
        endcase
    endfunction

    initial begin
        logic [15:0] scales [6];
        scales = '{16'd0, 16'd65535, 16'd256, 16'd1, 16'd804, 16'd5120};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed vectors at the reset time scale: zero, field extremes,
        // single axes and the smallest nonzero vector.
        send_vector(16'sd0, 16'sd0, 16'sd0);
        send_vector(16'sd1, 16'sd0, 16'sd0);
        send_vector(16'sd0, -16'sd1, 16'sd0);
        send_vector(16'sd0, 16'sd0, 16'sd4096);
        send_vector(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_vector(-16'sd32768, -16'sd32768, -16'sd32768);
        send_vector(-16'sd32768, 16'sh7FFF, 16'sd0);
        send_vector(16'sd4096, 16'sd4096, -16'sd4096);
        send_vector(16'sh5555, -16'sh2AAB, 16'sh1234);
        send_vector(16'sd0, 16'sd0, 16'sd0);

        // Zero time scale must give the identity without the zero flag.
        set_scale(16'd0);
        send_vector(16'sd4096, -16'sd200, 16'sd77);
        send_vector(16'sd0, 16'sd0, 16'sd0);

        // Random phases over several time scales, the extremes among them.
        for (int ph = 0; ph < 6; ph++) begin
            set_scale(ph == 4 ? 16'($urandom) : scales[ph]);
            if (ph == 5) quiet = 1;
            for (int i = 0; i < 85; i++) begin
                send_vector(rand_comp(), rand_comp(), rand_comp());
            end
        end
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("axis_angle_to_rotation_matrix_top: match");
        end else begin
            $display("axis_angle_to_rotation_matrix_top: mismatch");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #2000000;
        $display("axis_angle_to_rotation_matrix_top: mismatch");
        $finish;
    end
endmodule

// File: axis_angle_to_rotation_matrix_top.f
sv/aa2rm_pkg.sv
sv/axis_angle_to_rotation_matrix_top.sv
tb/sv/axis_angle_to_rotation_matrix_checker.sv
tb/sv/axis_angle_to_rotation_matrix_top_tb.sv
